@@ hdl/obva_pkg.sv @@
// shared types and constants for the on-balance volume average block
`default_nettype none

package obva_pkg;

    localparam int PRICE_W    = 32;
    localparam int VOL_W      = 40;
    localparam int TOTAL_W    = 48;
    localparam int CFG_W      = 7;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 96;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

    typedef struct packed {
        logic signed [TOTAL_W-1:0] total;
        logic                      first;
    } t_queue_entry;

endpackage

`default_nettype wire

@@ hdl/on_balance_volume_average.sv @@
// top level of the on-balance volume block with a moving average of its totals
//
//  channel   direction  transaction
//  s_axis    in         one price bar: close price, volume, first-bar flag
//  m_axis    out        one result: running total and window average
//  cfg       in         window length write, single register
//
// a bar with a result passes the back end states idle, subtract, add, divider
// setup, divide and output; the serial divider yields one quotient bit a cycle
// a bar that only fills the window passes the states idle, subtract and add
// reset is synchronous, the history ring needs no clearing pass
// the front end takes bars into a four-deep queue while the back end divides;
// a finished result waits in the output register, and the back end only stalls
// in its last step while the previous result has not been taken
`default_nettype none

module on_balance_volume_average #(
    parameter int WINDOW_MAX = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [obva_pkg::CFG_W-1:0]         i_cfg_wdata,   // window_len
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [obva_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // close_price, volume
    input  wire  [0:0]                         s_axis_tuser,  // first_bar
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [obva_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // obv_total, obv_average
);

    localparam int VOL_LO = obva_pkg::PRICE_W;
    localparam int VOL_HI = obva_pkg::PRICE_W + obva_pkg::VOL_W - 1;

    obva_pkg::t_queue_entry              push_entry;
    obva_pkg::t_queue_entry              pop_entry;
    logic                                push_valid;
    logic                                push_ready;
    logic                                pop_valid;
    logic                                pop_ready;
    logic signed [obva_pkg::TOTAL_W-1:0] obv_total;
    logic signed [obva_pkg::TOTAL_W-1:0] obv_average;

    // classify the bar and update the running total
    obva_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_close_price (s_axis_tdata[obva_pkg::PRICE_W-1:0]),
        .i_volume      (s_axis_tdata[VOL_HI:VOL_LO]),
        .i_first_bar   (s_axis_tuser[0]),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_entry  (push_entry)
    );

    // decouples bar intake from the averaging
    obva_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    // window bookkeeping, divide and result register
    obva_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_entry   (pop_entry),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_obv_total   (obv_total),
        .o_obv_average (obv_average)
    );

    assign m_axis_tdata = {obv_average, obv_total};

endmodule

`default_nettype wire

@@ hdl/obva_front.sv @@
// front end: accepts bars and keeps the saturated running total
`default_nettype none

module obva_front (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [obva_pkg::PRICE_W-1:0]         i_close_price,
    input  wire  [obva_pkg::VOL_W-1:0]           i_volume,
    input  wire                                  i_first_bar,
    output logic                                 o_push_valid,
    input  wire                                  i_push_ready,
    output obva_pkg::t_queue_entry               o_push_entry
);

    logic [obva_pkg::PRICE_W-1:0]        r_prev_close;
    logic signed [obva_pkg::TOTAL_W-1:0] r_total;
    logic signed [obva_pkg::TOTAL_W-1:0] n_total;
    logic [obva_pkg::TOTAL_W:0]          ext_total;
    logic [obva_pkg::TOTAL_W:0]          ext_vol;
    logic [obva_pkg::TOTAL_W:0]          sum;
    logic                                accept;

    assign accept    = i_valid && i_push_ready;
    assign ext_total = {r_total[obva_pkg::TOTAL_W-1], r_total};
    assign ext_vol   = {{(obva_pkg::TOTAL_W+1-obva_pkg::VOL_W){1'b0}}, i_volume};

    always_comb begin
        if (i_close_price > r_prev_close) begin
            sum = ext_total + ext_vol;
        end else begin
            sum = ext_total - ext_vol;
        end
        priority if (i_first_bar) begin
            n_total = '0;
        end else if (i_close_price == r_prev_close) begin
            n_total = r_total;
        end else if (sum[obva_pkg::TOTAL_W] != sum[obva_pkg::TOTAL_W-1]) begin
            // overflow: clamp toward the sign of the true result
            n_total = sum[obva_pkg::TOTAL_W] ? obva_pkg::TOTAL_MIN : obva_pkg::TOTAL_MAX;
        end else begin
            n_total = sum[obva_pkg::TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_close <= '0;
            r_total      <= '0;
        end else if (accept) begin
            r_prev_close <= i_close_price;
            r_total      <= n_total;
        end
    end

    assign o_ready            = i_push_ready;
    assign o_push_valid       = i_valid;
    assign o_push_entry.total = n_total;
    assign o_push_entry.first = i_first_bar;

endmodule

`default_nettype wire

@@ hdl/obva_queue.sv @@
// short queue of classified bars between front and back
`default_nettype none

module obva_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push_valid,
    output logic                    o_push_ready,
    input  obva_pkg::t_queue_entry  i_push_entry,
    output logic                    o_pop_valid,
    input  wire                     i_pop_ready,
    output obva_pkg::t_queue_entry  o_pop_entry
);

    obva_pkg::t_queue_entry           r_slots [obva_pkg::QUEUE_DEPTH];
    logic [obva_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [obva_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [obva_pkg::QPTR_W:0]        r_count;
    logic                             push;
    logic                             pop;

    assign o_push_ready = (r_count != (obva_pkg::QPTR_W+1)'(obva_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_entry  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slots[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/obva_back.sv @@
// back end: history ring, window sum, serial divider and output register
`default_nettype none

module obva_back #(
    parameter int WINDOW_MAX = 64
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [obva_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  wire                                   i_pop_valid,
    output logic                                  o_pop_ready,
    input  obva_pkg::t_queue_entry                i_pop_entry,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic signed [obva_pkg::TOTAL_W-1:0]   o_obv_total,
    output logic signed [obva_pkg::TOTAL_W-1:0]   o_obv_average
);

    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int CMP_W  = (LEN_W > obva_pkg::CFG_W) ? LEN_W : obva_pkg::CFG_W;
    localparam int SUM_W  = obva_pkg::TOTAL_W + $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(SUM_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUB  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_DSET = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    function automatic logic [LEN_W-1:0] eff_len(input logic [obva_pkg::CFG_W-1:0] x);
        logic [CMP_W-1:0] v;
        v = CMP_W'(x);
        if (v == '0) begin
            return LEN_W'(1);
        end else if (v > CMP_W'(WINDOW_MAX)) begin
            return LEN_W'(WINDOW_MAX);
        end
        return LEN_W'(v);
    endfunction

    logic signed [obva_pkg::TOTAL_W-1:0] r_hist [WINDOW_MAX];
    logic signed [obva_pkg::TOTAL_W-1:0] r_rd_data;

    logic [2:0]                          r_state, n_state;
    logic [LEN_W-1:0]                    r_len, n_len;
    logic [LEN_W-1:0]                    r_bars, n_bars;
    logic [SLOT_W-1:0]                   r_write_slot, n_write_slot;
    logic [SLOT_W-1:0]                   r_slot, n_slot;
    logic signed [SUM_W-1:0]             r_sum, n_sum;
    logic signed [obva_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [SUM_W-1:0]                    r_quo, n_quo;
    logic [LEN_W-1:0]                    r_rem, n_rem;
    logic                                r_neg, n_neg;
    logic [CNT_W-1:0]                    r_cnt, n_cnt;
    logic                                r_out_valid, n_out_valid;
    logic signed [obva_pkg::TOTAL_W-1:0] r_out_total, n_out_total;
    logic signed [obva_pkg::TOTAL_W-1:0] r_out_avg, n_out_avg;

    logic                                mem_re;
    logic                                mem_we;
    logic [SLOT_W-1:0]                   rd_addr;
    logic [LEN_W-1:0]                    slot_inc;
    logic [LEN_W:0]                      rem_sh;
    logic                                rem_ge;
    logic [SUM_W-1:0]                    avg_full;
    logic [LEN_W-1:0]                    bars_new;

    assign o_pop_ready = (r_state == S_IDLE);
    assign mem_re      = (r_state == S_IDLE) && i_pop_valid;
    assign mem_we      = (r_state == S_ADD);
    assign rd_addr     = (i_pop_entry.first || (LEN_W'(r_write_slot) >= r_len))
                         ? '0 : r_write_slot;
    assign slot_inc    = LEN_W'(r_slot) + 1'b1;
    assign rem_sh      = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge      = (rem_sh >= {1'b0, r_len});
    assign avg_full    = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign bars_new    = (r_bars < r_len) ? (r_bars + 1'b1) : r_bars;

    // history ring with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[r_slot] <= r_total;
        end
        if (mem_re) begin
            r_rd_data <= r_hist[rd_addr];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_bars       = r_bars;
        n_write_slot = r_write_slot;
        n_slot       = r_slot;
        n_sum        = r_sum;
        n_total      = r_total;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_neg        = r_neg;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_out_total  = r_out_total;
        n_out_avg    = r_out_avg;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_total = i_pop_entry.total;
                    n_slot  = rd_addr;
                    if (i_pop_entry.first) begin
                        n_sum  = '0;
                        n_bars = '0;
                    end
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                // drop the oldest total once the window is full
                if (r_bars >= r_len) begin
                    n_sum = r_sum - {{(SUM_W-obva_pkg::TOTAL_W){r_rd_data[obva_pkg::TOTAL_W-1]}},
                                     r_rd_data};
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                n_sum        = r_sum + {{(SUM_W-obva_pkg::TOTAL_W){r_total[obva_pkg::TOTAL_W-1]}},
                                        r_total};
                n_write_slot = (slot_inc >= r_len) ? '0 : SLOT_W'(slot_inc);
                n_bars       = bars_new;
                n_state      = (bars_new >= r_len) ? S_DSET : S_IDLE;
            end
            S_DSET: begin
                n_neg   = r_sum[SUM_W-1];
                n_quo   = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
                n_rem   = '0;
                n_cnt   = CNT_W'(SUM_W);
                n_state = S_DIV;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                n_rem = rem_ge ? LEN_W'(rem_sh - {1'b0, r_len}) : rem_sh[LEN_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], rem_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_total = r_total;
                    n_out_avg   = avg_full[obva_pkg::TOTAL_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // window length write empties the window
        if (i_cfg_we) begin
            n_len        = eff_len(i_cfg_wdata);
            n_sum        = '0;
            n_bars       = '0;
            n_write_slot = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= eff_len(obva_pkg::WINDOW_LEN_RESET);
            r_bars       <= '0;
            r_write_slot <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_len        <= n_len;
            r_bars       <= n_bars;
            r_write_slot <= n_write_slot;
            r_sum        <= n_sum;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_total     <= n_total;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_neg       <= n_neg;
        r_cnt       <= n_cnt;
        r_out_total <= n_out_total;
        r_out_avg   <= n_out_avg;
    end

    assign o_valid       = r_out_valid;
    assign o_obv_total   = r_out_total;
    assign o_obv_average = r_out_avg;

endmodule

`default_nettype wire

@@ bench/obva_checker.sv @@
`timescale 1ns / 1ps
// checker for the on-balance volume block: watches the bar, result and config channels

module obva_checker #(
    parameter int WINDOW_MAX = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [obva_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    input  wire  [obva_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  wire  [0:0]                       i_s_tuser,
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    input  wire  [obva_pkg::OUT_DATA_W-1:0]  i_m_tdata,
    output int                               o_pending,
    output int                               o_errors,
    output int                               o_results
);

    typedef struct packed {
        logic signed [obva_pkg::TOTAL_W-1:0] average;
        logic signed [obva_pkg::TOTAL_W-1:0] total;
    } t_obv_result;

    t_obv_result                         obv_expected[$];
    logic [obva_pkg::CFG_W-1:0]          win_reg;
    logic [obva_pkg::PRICE_W-1:0]        last_close;
    logic signed [obva_pkg::TOTAL_W-1:0] obv_now;
    logic signed [obva_pkg::TOTAL_W-1:0] obv_ring [WINDOW_MAX];
    logic signed [54:0]                  ring_sum;
    int unsigned                         fill_count;
    int unsigned                         ring_slot;
    int                                  mismatch_count = 0;
    int                                  result_count = 0;

    task automatic clear_window();
        ring_sum   = '0;
        fill_count = 0;
        ring_slot  = 0;
    endtask

    // advance the running total and the window by one bar
    task automatic advance_obv(input logic [obva_pkg::PRICE_W-1:0] close,
                               input logic [obva_pkg::VOL_W-1:0] vol,
                               input logic first);
        longint             wide;
        longint             vol_ext;
        int unsigned        len;
        int unsigned        slot;
        logic signed [54:0] len_s;
        t_obv_result        res;
        len = (win_reg == 0) ? 1 : ((win_reg > WINDOW_MAX) ? WINDOW_MAX : win_reg);
        vol_ext = {24'b0, vol};
        if (first) begin
            obv_now = '0;
            clear_window();
        end else if (close != last_close) begin
            wide = obv_now;
            if (close > last_close) begin
                wide = wide + vol_ext;
            end else begin
                wide = wide - vol_ext;
            end
            // saturate at the 48-bit signed limits
            if (wide > obva_pkg::TOTAL_MAX) begin
                wide = obva_pkg::TOTAL_MAX;
            end else if (wide < obva_pkg::TOTAL_MIN) begin
                wide = obva_pkg::TOTAL_MIN;
            end
            obv_now = wide[obva_pkg::TOTAL_W-1:0];
        end
        last_close = close;

        slot = (ring_slot >= len) ? 0 : ring_slot;
        if (fill_count >= len) begin
            ring_sum = ring_sum - obv_ring[slot];
        end
        obv_ring[slot] = obv_now;
        ring_sum = ring_sum + obv_now;
        slot++;
        ring_slot = (slot >= len) ? 0 : slot;
        if (fill_count < len) begin
            fill_count++;
        end
        if (fill_count >= len) begin
            len_s = 55'(len);
            res.total   = obv_now;
            res.average = obva_pkg::TOTAL_W'(ring_sum / len_s);
            obv_expected.insert(obv_expected.size(), res);
        end
    endtask

    task automatic check_result(input logic [obva_pkg::OUT_DATA_W-1:0] data);
        t_obv_result got;
        t_obv_result want;
        got = data;
        result_count++;
        if (obv_expected.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, nothing pending, got total %0d average %0d",
                     $time, got.total, got.average);
        end else begin
            want = obv_expected.pop_front();
            if (got.total !== want.total) begin
                mismatch_count++;
                $display("%0t: obv_total mismatch, expected %0d, got %0d",
                         $time, want.total, got.total);
            end
            if (got.average !== want.average) begin
                mismatch_count++;
                $display("%0t: obv_average mismatch, expected %0d, got %0d",
                         $time, want.average, got.average);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_reg    = obva_pkg::WINDOW_LEN_RESET;
            last_close = '0;
            obv_now    = '0;
            clear_window();
            obv_expected.delete();
        end else begin
            if (i_cfg_we) begin
                win_reg = i_cfg_wdata;
                clear_window();
            end
            // results first, so a spurious one never pairs with a bar taken this cycle
            if (i_m_tvalid && i_m_tready) begin
                check_result(i_m_tdata);
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_obv(i_s_tdata[obva_pkg::PRICE_W-1:0],
                            i_s_tdata[obva_pkg::PRICE_W +: obva_pkg::VOL_W], i_s_tuser[0]);
            end
        end
        o_pending <= obv_expected.size();
        o_errors  <= mismatch_count;
        o_results <= result_count;
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// top of the bench: clock, reset, bar stimulus, window writes and the verdict

module tb;

    localparam int WINDOW_MAX    = 64;
    // generous cap, several times the slowest legal run
    localparam int LIMIT_CYCLES  = 1_000_000;
    // back end can still hold up to five non-result bars after the last result
    localparam int SETTLE_CYCLES = 500;
    localparam int PHASE_BARS    = 75;
    localparam int RUN_BARS      = 160;
    localparam logic [obva_pkg::VOL_W-1:0] VOL_MAX = {obva_pkg::VOL_W{1'b1}};

    typedef enum int {WALK, NOISE, BROKEN, RUN_UP, RUN_DOWN} t_series_kind;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [obva_pkg::CFG_W-1:0]      i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [obva_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // close_price, volume
    logic [0:0]                      s_axis_tuser = '0;   // first_bar
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [obva_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // obv_total, obv_average

    int chk_pending;
    int chk_errors;
    int chk_results;

    int cycle_count = 0;
    int tx_idle_pct = 20;
    int rx_idle_pct = 86;
    int bars_sent = 0;
    int window_writes = 0;
    logic [obva_pkg::PRICE_W-1:0] cur_close = '0;

    on_balance_volume_average #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    obva_checker #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_pending   (chk_pending),
        .o_errors    (chk_errors),
        .o_results   (chk_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, chk_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // one bar transaction, with random idle cycles in front of it
    task automatic send_bar(input logic [obva_pkg::PRICE_W-1:0] close,
                            input logic [obva_pkg::VOL_W-1:0] vol,
                            input logic first);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vol, close};
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bars_sent++;
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    // window length writes only happen with the block idle
    task automatic write_window(input logic [obva_pkg::CFG_W-1:0] len);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        window_writes++;
    endtask

    function automatic logic [obva_pkg::VOL_W-1:0] pick_volume();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        unique case ($urandom_range(9, 0))
            0: return '0;
            1: return VOL_MAX;
            2, 3, 4: return obva_pkg::VOL_W'($urandom_range(5000, 0) * 100);   // whole lots
            default: return raw[obva_pkg::VOL_W-1:0];
        endcase
    endfunction

    function automatic logic [obva_pkg::PRICE_W-1:0] step_close(
        input logic [obva_pkg::PRICE_W-1:0] prev);
        unique case ($urandom_range(9, 0))
            0, 1: return prev;                                    // flat bar
            2: return $urandom;
            3, 4, 5: return prev + $urandom_range(500, 1);
            default: return prev - $urandom_range(500, 1);
        endcase
    endfunction

    // one series of bars; walks start with first_bar, broken ones carry on mid-series
    task automatic send_series(input t_series_kind kind, input int n_bars);
        logic first;
        for (int i = 0; i < n_bars; i++) begin
            unique case (kind)
                NOISE: begin
                    cur_close = $urandom;
                    send_bar(cur_close, pick_volume(), ($urandom_range(99, 0) < 15));
                end
                RUN_UP, RUN_DOWN: begin
                    // long one-way trend with near full volume drives the total into the clamp
                    if (i == 0) begin
                        cur_close = (kind == RUN_UP) ? $urandom_range(1000, 0) : '1;
                    end else if ($urandom_range(99, 0) >= 5) begin
                        cur_close = (kind == RUN_UP) ? cur_close + $urandom_range(3000, 1)
                                                     : cur_close - $urandom_range(3000, 1);
                    end
                    send_bar(cur_close, VOL_MAX - $urandom_range(1000, 0), (i == 0));
                end
                default: begin
                    first = (kind == WALK) && (i == 0);
                    cur_close = step_close(cur_close);
                    send_bar(cur_close, pick_volume(), first);
                end
            endcase
        end
    endtask

    task automatic send_random_bars(input int n_bars);
        int left;
        int len;
        int roll;
        left = n_bars;
        while (left > 0) begin
            roll = $urandom_range(99, 0);
            if (roll < 70) begin
                len = $urandom_range(70, 1);
                len = (len > left) ? left : len;
                send_series(WALK, len);
            end else if (roll < 85) begin
                len = $urandom_range(10, 1);
                len = (len > left) ? left : len;
                send_series(NOISE, len);
            end else begin
                len = $urandom_range(30, 1);
                len = (len > left) ? left : len;
                send_series(BROKEN, len);
            end
            left -= len;
        end
    endtask

    initial begin
        logic [obva_pkg::CFG_W-1:0] phase_len [12];

        // window lengths per phase: extremes, zero and out-of-range values among them
        phase_len = '{7'd64, 7'd0, 7'd127, 7'd2, 7'd65, 7'd9,
                      7'd1, 7'd100, 7'd32, 7'd4, 7'd5, 7'd64};
        phase_len[9] = obva_pkg::CFG_W'($urandom_range(WINDOW_MAX, 1));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset window of five
        // first bar after reset without first_bar compares against a close of zero
        send_bar(32'd1000, VOL_MAX, 1'b0);
        send_bar(32'd1000, 40'd12345, 1'b0);             // flat close, total unchanged
        send_bar(32'd0, VOL_MAX, 1'b0);                  // lowest close subtracts
        send_bar(32'hFFFF_FFFF, '0, 1'b0);               // highest close, zero volume
        send_bar(32'd7, 40'hAA_AAAA_AAAA, 1'b0);         // window full, first result
        send_bar(32'd8, 40'h55_5555_5555, 1'b0);
        send_bar(32'hFFFF_FFFF, VOL_MAX, 1'b1);          // new series empties the window
        send_bar(32'hFFFF_FFFE, VOL_MAX, 1'b0);
        send_bar(32'hFFFF_FFFE, 40'd1, 1'b0);
        send_bar(32'd0, VOL_MAX, 1'b0);
        send_bar(32'd1, 40'd100, 1'b0);
        send_bar(32'd2, 40'd0, 1'b0);

        // window of one: every bar is a result
        write_window(7'd1);
        send_bar(32'd50, 40'd77, 1'b1);
        send_bar(32'd40, VOL_MAX, 1'b0);
        send_bar(32'd60, 40'd3, 1'b0);

        // negative window sums must truncate toward zero
        write_window(7'd3);
        send_bar(32'd100, 40'd9, 1'b1);
        send_bar(32'd99, 40'd1, 1'b0);
        send_bar(32'd99, 40'd5, 1'b0);                   // -2 / 3 gives 0
        send_bar(32'd98, 40'd2, 1'b0);                   // -5 / 3 gives -1
        cur_close = 32'd98;

        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                tx_idle_pct = 86;
                rx_idle_pct = 20;
            end else if (p == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_window(phase_len[p]);
            if (p == 0) begin
                send_series(RUN_UP, RUN_BARS);
            end else if (p == 2) begin
                send_series(RUN_DOWN, RUN_BARS);
            end
            if (p == 5) begin
                // hold the sender until the block has delivered everything
                send_random_bars(PHASE_BARS / 2);
                drain();
                send_random_bars(PHASE_BARS - PHASE_BARS / 2);
            end else begin
                send_random_bars(PHASE_BARS);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d bars, checked %0d results over %0d window length writes",
                 bars_sent, chk_results, window_writes);
        $display("covered flat, rising and falling closes, clamping both ways, windows 0..127");
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
